[hw/rtl/ile_pkg.sv]
// ----------------------------------------------------------------------------
// ile_pkg
// Shared constants, codes and beat types for the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int OUT_CW   = 6;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_REVERSE = 2'd2,
    OP_DUMP    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_DUMP
  } state_t;

  typedef struct packed {
    opcode_t                   opcode;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value_in;
  } cmd_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  value_out;
    logic [OUT_CW-1:0]         count;
    logic                      last;
  } res_t;

endpackage

[hw/rtl/indexed_list_engine.sv]
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of signed 32-bit values with insert, delete, reverse and dump.
// ----------------------------------------------------------------------------
//  channel   handshake            payload        note
//  command   start & !busy        cmd    (cmd_t) one operation per beat
//  result    done (one cycle)     result (res_t) cannot be held off
//
// Entries sit packed in a single-port-write RAM; a direction flag gives the
// logical order, so reverse only flips the flag and moves no entry. Insert and
// delete walk the entries they move through the RAM's single write port, and
// dump walks the list in logical order; reverse and any failed operation answer
// without a walk. busy is high while a walk runs. Reset (rst, synchronous)
// empties the list.
// ----------------------------------------------------------------------------
module indexed_list_engine import ile_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic done,
  output res_t result
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              rev, rev_next;
  logic              pend, pend_next;
  logic              done_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  ph, ph_next;
  logic [ADDR_W-1:0] paddr, paddr_next;
  logic              pfirst, pfirst_next;
  logic              plast, plast_next;
  logic [DATA_W-1:0] take, take_next;
  logic [DATA_W-1:0] val, val_next;
  res_t              res_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic [CMP_W-1:0]  pos_x, cnt_x;

  ile_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  function automatic res_t mk_res(status_t s, logic [DATA_W-1:0] v,
                                  logic [CNT_W-1:0] n, logic l);
    res_t r;
    r.status    = s;
    r.value_out = v;
    r.count     = OUT_CW'(n);
    r.last      = l;
    return r;
  endfunction

  assign busy  = (state != S_IDLE);
  assign pos_x = CMP_W'(cmd.position);
  assign cnt_x = CMP_W'(cnt);

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    rev_next    = rev;
    pend_next   = pend;
    done_next   = 1'b0;
    idx_next    = idx;
    ph_next     = ph;
    paddr_next  = paddr;
    pfirst_next = pfirst;
    plast_next  = plast;
    take_next   = take;
    val_next    = val;
    res_next    = result;
    ram_we      = 1'b0;
    ram_waddr   = paddr;
    ram_wdata   = ram_rdata;
    ram_raddr   = idx[ADDR_W-1:0];

    case (state)
      S_IDLE: begin
        pend_next = 1'b0;
        if (start) begin
          case (cmd.opcode)
            OP_INSERT: begin
              if (pos_x > cnt_x) begin
                done_next = 1'b1;
                res_next  = mk_res(ST_BAD_POS, '0, cnt, 1'b1);
              end else if (cnt_x >= CMP_W'(CAPACITY)) begin
                done_next = 1'b1;
                res_next  = mk_res(ST_FULL, '0, cnt, 1'b1);
              end else begin
                // physical slot of the new entry, walk down from the top
                ph_next    = rev ? cnt - CNT_W'(cmd.position) : CNT_W'(cmd.position);
                idx_next   = cnt;
                val_next   = cmd.value_in;
                state_next = S_INS;
              end
            end
            OP_DELETE: begin
              if (cnt == '0) begin
                done_next = 1'b1;
                res_next  = mk_res(ST_EMPTY, '1, cnt, 1'b1);
              end else if (pos_x >= cnt_x) begin
                done_next = 1'b1;
                res_next  = mk_res(ST_BAD_POS, '1, cnt, 1'b1);
              end else begin
                idx_next    = rev ? cnt - CNT_W'(1) - CNT_W'(cmd.position)
                                  : CNT_W'(cmd.position);
                pfirst_next = 1'b1;
                state_next  = S_DEL;
              end
            end
            OP_REVERSE: begin
              rev_next  = ~rev;
              done_next = 1'b1;
              res_next  = mk_res(ST_OK, '0, cnt, 1'b1);
            end
            OP_DUMP: begin
              if (cnt == '0) begin
                done_next = 1'b1;
                res_next  = mk_res(ST_EMPTY, '0, cnt, 1'b1);
              end else begin
                idx_next   = '0;
                state_next = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end

      S_INS: begin
        ram_raddr = ADDR_W'(idx - CNT_W'(1));
        if (pend) begin
          ram_we = 1'b1;
        end
        if (idx > ph) begin
          pend_next  = 1'b1;
          paddr_next = idx[ADDR_W-1:0];
          idx_next   = idx - CNT_W'(1);
        end else if (pend) begin
          pend_next = 1'b0;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = ph[ADDR_W-1:0];
          ram_wdata  = val;
          cnt_next   = cnt + CNT_W'(1);
          done_next  = 1'b1;
          res_next   = mk_res(ST_OK, '0, cnt + CNT_W'(1), 1'b1);
          state_next = S_IDLE;
        end
      end

      S_DEL: begin
        // first beat read back is the removed entry, the rest move down one
        if (pend) begin
          if (pfirst) begin
            take_next = ram_rdata;
          end else begin
            ram_we = 1'b1;
          end
        end
        if (idx < cnt) begin
          pend_next   = 1'b1;
          pfirst_next = (state == S_DEL) && pend ? 1'b0 : pfirst;
          paddr_next  = ADDR_W'(idx - CNT_W'(1));
          idx_next    = idx + CNT_W'(1);
        end else if (pend) begin
          pend_next   = 1'b0;
          pfirst_next = 1'b0;
        end else begin
          cnt_next   = cnt - CNT_W'(1);
          done_next  = 1'b1;
          res_next   = mk_res(ST_OK, take, cnt - CNT_W'(1), 1'b1);
          state_next = S_IDLE;
        end
      end

      S_DUMP: begin
        ram_raddr = rev ? ADDR_W'(cnt - CNT_W'(1) - idx) : idx[ADDR_W-1:0];
        if (pend) begin
          done_next = 1'b1;
          res_next  = mk_res(ST_OK, ram_rdata, cnt, plast);
        end
        if (idx < cnt) begin
          pend_next  = 1'b1;
          plast_next = (idx == cnt - CNT_W'(1));
          idx_next   = idx + CNT_W'(1);
        end else begin
          pend_next  = 1'b0;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      rev   <= 1'b0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      rev   <= rev_next;
      pend  <= pend_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    ph     <= ph_next;
    paddr  <= paddr_next;
    pfirst <= pfirst_next;
    plast  <= plast_next;
    take   <= take_next;
    val    <= val_next;
    result <= res_next;
  end

endmodule

[hw/rtl/ile_ram.sv]
// ----------------------------------------------------------------------------
// ile_ram
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ile_ram import ile_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for indexed_list_engine. A directed table covers the
// empty, one-entry and boundary cases, then random traffic grows the list to
// full and drains it again. Every beat on the result port is compared, field
// by field, with a queue-based model of the list or a beat typed in the table.
// ----------------------------------------------------------------------------
module tb;
  import ile_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int RAND_PER_PHASE = 108;
  localparam int SETTLE_CYCLES  = 2 * CAPACITY + 8;
  localparam int N_DIRECTED     = 25;

  typedef logic signed [DATA_W-1:0] word_t;

  // Directed row: command, then the expected single beat where it is typed in.
  typedef struct packed {
    opcode_t           op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic              typed;
    status_t           st;
    logic [DATA_W-1:0] vo;
    logic [OUT_CW-1:0] cnt;
  } dir_row_t;

  logic clk;
  logic rst   = 1'b1;
  logic start = 1'b0;
  cmd_t cmd   = '0;
  logic busy;
  logic done;
  res_t result;

  word_t list_model[$];
  res_t  pending_res[$];
  res_t  want;
  bit    growing = 1'b1;
  int    idle_pct = 27;
  int    fail_count = 0;
  int    beats_checked = 0;
  int    ops_sent = 0;
  int    cycles = 0;
  int    status_hits[4] = '{0, 0, 0, 0};

  dir_row_t dir_tbl [0:N_DIRECTED-1] = '{
    '{OP_DUMP,    6'd0,  32'h00000000, 1'b1, ST_EMPTY,   32'h00000000, 6'd0},
    '{OP_DELETE,  6'd0,  32'h00000000, 1'b1, ST_EMPTY,   32'hFFFFFFFF, 6'd0},
    '{OP_DELETE,  6'd63, 32'hFFFFFFFF, 1'b1, ST_EMPTY,   32'hFFFFFFFF, 6'd0},
    '{OP_REVERSE, 6'd0,  32'h00000000, 1'b1, ST_OK,      32'h00000000, 6'd0},
    '{OP_INSERT,  6'd1,  32'h00000005, 1'b1, ST_BAD_POS, 32'h00000000, 6'd0},
    '{OP_INSERT,  6'd0,  32'h7FFFFFFF, 1'b1, ST_OK,      32'h00000000, 6'd1},
    '{OP_REVERSE, 6'd0,  32'h00000000, 1'b1, ST_OK,      32'h00000000, 6'd1},
    '{OP_DUMP,    6'd0,  32'h00000000, 1'b1, ST_OK,      32'h7FFFFFFF, 6'd1},
    '{OP_INSERT,  6'd1,  32'h80000000, 1'b1, ST_OK,      32'h00000000, 6'd2},
    '{OP_INSERT,  6'd63, 32'h00000001, 1'b1, ST_BAD_POS, 32'h00000000, 6'd2},
    '{OP_INSERT,  6'd3,  32'h00000001, 1'b1, ST_BAD_POS, 32'h00000000, 6'd2},
    '{OP_INSERT,  6'd1,  32'hFFFFFFFF, 1'b1, ST_OK,      32'h00000000, 6'd3},
    '{OP_INSERT,  6'd0,  32'h00000000, 1'b1, ST_OK,      32'h00000000, 6'd4},
    '{OP_DUMP,    6'd42, 32'h12345678, 1'b0, ST_OK,      32'h00000000, 6'd0},
    '{OP_REVERSE, 6'd63, 32'hFFFFFFFF, 1'b1, ST_OK,      32'h00000000, 6'd4},
    '{OP_DUMP,    6'd0,  32'h00000000, 1'b0, ST_OK,      32'h00000000, 6'd0},
    '{OP_DELETE,  6'd4,  32'h00000000, 1'b1, ST_BAD_POS, 32'hFFFFFFFF, 6'd4},
    '{OP_DELETE,  6'd32, 32'h00000000, 1'b1, ST_BAD_POS, 32'hFFFFFFFF, 6'd4},
    '{OP_DELETE,  6'd0,  32'h00000000, 1'b0, ST_OK,      32'h00000000, 6'd0},
    '{OP_DELETE,  6'd2,  32'h00000000, 1'b0, ST_OK,      32'h00000000, 6'd0},
    '{OP_INSERT,  6'd32, 32'hAAAAAAAA, 1'b1, ST_BAD_POS, 32'h00000000, 6'd2},
    '{OP_INSERT,  6'd2,  32'h55555555, 1'b0, ST_OK,      32'h00000000, 6'd0},
    '{OP_DUMP,    6'd0,  32'h00000000, 1'b0, ST_OK,      32'h00000000, 6'd0},
    '{OP_DELETE,  6'd1,  32'h00000000, 1'b0, ST_OK,      32'h00000000, 6'd0},
    '{OP_DUMP,    6'd0,  32'h00000000, 1'b0, ST_OK,      32'h00000000, 6'd0}
  };

  indexed_list_engine dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles,
               pending_res.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Applies one command to the list copy and queues the beats it should give.
  task automatic predict_list_op(input cmd_t c);
    int    n;
    int    p;
    word_t tmp;
    res_t  r;
    n = list_model.size();
    p = int'(c.position);
    r.status    = ST_OK;
    r.value_out = '0;
    r.count     = '0;
    r.last      = 1'b1;
    case (c.opcode)
      OP_INSERT: begin
        if (p > n) r.status = ST_BAD_POS;
        else if (n >= CAPACITY) r.status = ST_FULL;
        else list_model.insert(p, c.value_in);
      end
      OP_DELETE: begin
        if (n == 0) begin
          r.status    = ST_EMPTY;
          r.value_out = '1;
        end else if (p >= n) begin
          r.status    = ST_BAD_POS;
          r.value_out = '1;
        end else begin
          r.value_out = list_model[p];
          list_model.delete(p);
        end
      end
      OP_REVERSE: begin
        for (int i = 0; i < n / 2; i++) begin
          tmp                 = list_model[i];
          list_model[i]       = list_model[n-1-i];
          list_model[n-1-i]   = tmp;
        end
      end
      default: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.count = OUT_CW'(n);
          for (int i = 0; i < n; i++) begin
            r.value_out = list_model[i];
            r.last      = (i == n - 1);
            pending_res.push_back(r);
          end
          return;
        end
      end
    endcase
    r.count = OUT_CW'(list_model.size());
    pending_res.push_back(r);
  endtask

  // Biased towards valid positions; swings between filling and draining so
  // the full and empty corners both come round.
  function automatic cmd_t random_list_op();
    cmd_t c;
    int   n;
    int   roll;
    n = list_model.size();
    if (n == CAPACITY && $urandom_range(2) == 0) growing = 1'b0;
    else if (n == 0) growing = 1'b1;
    roll = $urandom_range(99);
    if (growing)
      c.opcode = (roll < 60) ? OP_INSERT : (roll < 75) ? OP_DELETE :
                 (roll < 85) ? OP_REVERSE : OP_DUMP;
    else
      c.opcode = (roll < 15) ? OP_INSERT : (roll < 75) ? OP_DELETE :
                 (roll < 85) ? OP_REVERSE : OP_DUMP;
    if ($urandom_range(99) < 15) c.position = POS_W'($urandom_range(63));
    else if (c.opcode == OP_DELETE && n > 0) c.position = POS_W'($urandom_range(n - 1));
    else c.position = POS_W'($urandom_range(n));
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: c.value_in = 32'h0000_0000;
        1: c.value_in = 32'hFFFF_FFFF;
        2: c.value_in = 32'h7FFF_FFFF;
        default: c.value_in = 32'h8000_0000;
      endcase
    end else begin
      c.value_in = $urandom;
    end
    return c;
  endfunction

  task automatic send_list_op(input cmd_t c, input bit typed, input res_t given);
    int gap;
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_list_op(c);
    if (typed) begin
      void'(pending_res.pop_back());
      pending_res.push_back(given);
    end
    ops_sent++;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_res.size() != 0);
  endtask

  task automatic flag_fault(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_res.size() == 0) begin
        flag_fault($sformatf("unexpected beat st=%0d val=%0d cnt=%0d last=%0b",
                             result.status, result.value_out, result.count, result.last));
      end else begin
        want = pending_res.pop_front();
        beats_checked++;
        status_hits[want.status]++;
        if (result.status !== want.status || result.value_out !== want.value_out ||
            result.count !== want.count || result.last !== want.last)
          flag_fault($sformatf({"beat %0d: expected st=%0d val=%0d cnt=%0d last=%0b, ",
                                "got st=%0d val=%0d cnt=%0d last=%0b"}, beats_checked,
                               want.status, want.value_out, want.count, want.last,
                               result.status, result.value_out, result.count, result.last));
      end
    end
  end

  initial begin
    cmd_t c;
    res_t given;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i]) begin
      c.opcode        = dir_tbl[i].op;
      c.position      = dir_tbl[i].pos;
      c.value_in      = dir_tbl[i].val;
      given.status    = dir_tbl[i].st;
      given.value_out = dir_tbl[i].vo;
      given.count     = dir_tbl[i].cnt;
      given.last      = 1'b1;
      send_list_op(c, dir_tbl[i].typed, given);
    end
    // hold off until the list engine has emitted everything
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 27 : (ph == 1) ? 77 : 0;
      for (int k = 0; k < RAND_PER_PHASE; k++)
        send_list_op(random_list_op(), 1'b0, '0);
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d commands, %0d result beats checked in %0d cycles", ops_sent,
             beats_checked, cycles);
    $display("status seen: ok %0d, bad position %0d, empty %0d, full %0d",
             status_hits[ST_OK], status_hits[ST_BAD_POS], status_hits[ST_EMPTY],
             status_hits[ST_FULL]);
    if (fail_count == 0 && pending_res.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d beats outstanding", fail_count, pending_res.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ile_pkg.sv
hw/rtl/ile_ram.sv
hw/rtl/indexed_list_engine.sv
test/tb.sv
